[rtl/lz10_pkg.sv]
// shared types and constants for the lz10 stream decompressor
// no dependencies; imported by every rtl module of the block
`default_nettype none

package lz10_pkg;

  // history window geometry
  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);

  // counter and register widths
  localparam int LEN_W = 24;
  localparam int CNT_W = 25;
  localparam int RUN_W = 5;

  // shortest copy run, added to the length nibble
  localparam logic [RUN_W-1:0] MIN_MATCH = 5'd3;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_OUT_LENGTH = 1'b0;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_stream;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       stream_done;
    logic       distance_error;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic restart;
    logic lit_emit;
    logic ref_hi_load;
    logic ref_start;
    logic prime_read;
    logic copy_step;
    logic err_emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ended_eff;
    logic dist_bad;
    logic reach_next;
    logic copy_last;
    logic slot_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/lz10_stream_decompressor.sv]
// lz10 stream decompressor: the input channel takes one payload byte per item
// (everything after the 4-byte header); the output channel gives one byte per item.
// a flag byte announces eight tokens, msb first: a literal byte or a two-byte
// back-reference that copies 3 to 18 bytes out of a 4096-byte history window.
// out_length (apb register at byte address 0) sets the expected output size;
// once reached, further bytes are swallowed until an item with first_of_stream.
// a flag byte or the first byte of a reference gives no result.
// a literal's byte appears in the output register next cycle.
// the second reference byte is followed by a priming window read, then the run
// leaves at one byte per cycle while the receiver does not stall.
// the window's single write and registered read port set that one byte a cycle.
// input is stalled while a run is copied and while a result waits in the output
// register under stall; a stalled receiver freezes the run where it stands.
// a bad distance gives one result with distance_error set and ends the stream.
// reset clears the decoder and out_length; the window needs no clearing because
// a distance never reaches bytes that this stream has not written.
// depends on lz10_pkg, lz10_ctrl and lz10_datapath
`default_nettype none

module lz10_stream_decompressor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lz10_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lz10_pkg::out_item_t                out_item,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lz10_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [lz10_pkg::CFG_DW-1:0]   pwdata,
  output logic [lz10_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);
  import lz10_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic             len_we;
  logic [LEN_W-1:0] len_value;

  // register port, always ready
  assign pready = 1'b1;
  assign len_we = psel && penable && pwrite && (paddr[2] == REG_OUT_LENGTH);

  always_comb begin
    if (paddr[2] == REG_OUT_LENGTH) begin
      prdata = CFG_DW'(len_value);
    end else begin
      prdata = '0;
    end
  end

  // sequencer
  lz10_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_item.in_byte),
    .in_first (in_item.first_of_stream),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window and counters
  lz10_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_item.in_byte),
    .in_first  (in_item.first_of_stream),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .len_we    (len_we),
    .len_wdata (pwdata[LEN_W-1:0]),
    .len_value (len_value)
  );

endmodule

`default_nettype wire

[rtl/lz10_ctrl.sv]
// token decoder and copy sequencer for the lz10 stream decompressor
// depends on lz10_pkg for the command and status structs
`default_nettype none

module lz10_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_first,
  input  wire lz10_pkg::stat_t stat,
  output lz10_pkg::cmd_t       cmd
);
  import lz10_pkg::*;

  typedef enum logic [4:0] {
    ST_FLAG  = 5'b00001,
    ST_TOKEN = 5'b00010,
    ST_REF2  = 5'b00100,
    ST_PRIME = 5'b01000,
    ST_COPY  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [2:0] tok_r, tok_nxt;
  logic       fin_r, fin_nxt;

  state_t     eff_state;
  logic       accept;
  logic       ended;
  logic       flag_bit;
  state_t     tok_end_state;
  logic [2:0] tok_end_idx;

  // input is taken only in a decode state with room in the output register
  always_comb begin
    in_stall = !(state_r inside {ST_FLAG, ST_TOKEN, ST_REF2}) || !stat.slot_free;
  end
  assign accept = in_valid && !in_stall;

  // a restart item is decoded as a flag byte of a fresh stream
  assign eff_state = in_first ? ST_FLAG : state_r;
  assign ended     = (fin_r && !in_first) || stat.ended_eff;
  assign flag_bit  = flags_r[3'd7 - tok_r];

  // next token after the current one finishes
  always_comb begin
    if (tok_r == 3'd7) begin
      tok_end_state = ST_FLAG;
      tok_end_idx   = 3'd0;
    end else begin
      tok_end_state = ST_TOKEN;
      tok_end_idx   = tok_r + 3'd1;
    end
  end

  // main sequencer
  always_comb begin
    state_nxt = state_r;
    flags_nxt = flags_r;
    tok_nxt   = tok_r;
    fin_nxt   = fin_r;
    cmd       = '0;

    case (state_r)
      ST_FLAG, ST_TOKEN, ST_REF2: begin
        if (accept) begin
          if (in_first) begin
            cmd.restart = 1'b1;
            fin_nxt     = 1'b0;
            state_nxt   = ST_FLAG;
            tok_nxt     = 3'd0;
          end
          if (!ended) begin
            case (eff_state)
              ST_TOKEN: begin
                if (flag_bit) begin
                  cmd.ref_hi_load = 1'b1;
                  state_nxt       = ST_REF2;
                end else begin
                  cmd.lit_emit = 1'b1;
                  state_nxt    = tok_end_state;
                  tok_nxt      = tok_end_idx;
                  if (stat.reach_next) begin
                    fin_nxt = 1'b1;
                  end
                end
              end
              ST_REF2: begin
                if (stat.dist_bad) begin
                  cmd.err_emit = 1'b1;
                  fin_nxt      = 1'b1;
                end else begin
                  cmd.ref_start = 1'b1;
                  state_nxt     = ST_PRIME;
                end
              end
              default: begin
                flags_nxt = in_byte;
                tok_nxt   = 3'd0;
                state_nxt = ST_TOKEN;
              end
            endcase
          end
        end
      end
      ST_PRIME: begin
        cmd.prime_read = 1'b1;
        state_nxt      = ST_COPY;
      end
      ST_COPY: begin
        if (stat.slot_free) begin
          cmd.copy_step = 1'b1;
          if (stat.copy_last) begin
            state_nxt = tok_end_state;
            tok_nxt   = tok_end_idx;
            if (stat.reach_next) begin
              fin_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_FLAG;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FLAG;
      flags_r <= 8'd0;
      tok_r   <= 3'd0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flags_r <= flags_nxt;
      tok_r   <= tok_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lz10_datapath.sv]
// history window, counters and output register of the lz10 decompressor
// depends on lz10_pkg; driven by commands from lz10_ctrl
`default_nettype none

module lz10_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         in_first,
  input  wire lz10_pkg::cmd_t               cmd,
  output lz10_pkg::stat_t                   stat,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output lz10_pkg::out_item_t               out_item,
  input  wire logic                         len_we,
  input  wire logic [lz10_pkg::LEN_W-1:0]   len_wdata,
  output logic [lz10_pkg::LEN_W-1:0]        len_value
);
  import lz10_pkg::*;

  logic [7:0]        win_mem [WIN_DEPTH];
  logic [7:0]        rd_q_r;

  logic [LEN_W-1:0]  len_r;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  bw_r, bw_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [WIN_AW-1:0] off_r, off_nxt;
  logic [WIN_AW-1:0] rp_r, rp_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         oi_r, oi_nxt;

  logic [WIN_AW-1:0] off_in;
  logic [CNT_W-1:0]  bw_inc;
  logic              bw_ge_len;
  logic              reach_next;
  logic              slot_free;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;

  // status towards the controller
  assign off_in     = {hi_r[3:0], in_byte};
  assign bw_inc     = bw_r + CNT_W'(1);
  assign bw_ge_len  = bw_r >= CNT_W'(len_r);
  assign reach_next = bw_inc >= CNT_W'(len_r);
  assign slot_free  = !ov_r || !out_stall;

  always_comb begin
    stat.ended_eff  = in_first ? (len_r == '0) : bw_ge_len;
    stat.dist_bad   = CNT_W'(off_in) >= bw_r;
    stat.reach_next = reach_next;
    stat.copy_last  = run_r == RUN_W'(1);
    stat.slot_free  = slot_free;
  end

  // window port control; with distance one the first read byte repeats
  assign wr_en   = cmd.lit_emit || cmd.copy_step;
  assign wr_data = cmd.lit_emit ? in_byte : rd_q_r;
  assign rd_en   = cmd.prime_read || (cmd.copy_step && (off_r != '0));
  assign rd_addr = cmd.prime_read ? rp_r : rp_r + WIN_AW'(1);

  // history window memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wp_r] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= win_mem[rd_addr];
    end
  end

  // pointers, counters and output register
  always_comb begin
    wp_nxt  = wp_r;
    bw_nxt  = bw_r;
    hi_nxt  = hi_r;
    off_nxt = off_r;
    rp_nxt  = rp_r;
    run_nxt = run_r;
    ov_nxt  = ov_r && out_stall;
    oi_nxt  = oi_r;

    if (cmd.restart) begin
      wp_nxt = '0;
      bw_nxt = '0;
      hi_nxt = 8'd0;
    end
    if (wr_en) begin
      wp_nxt = wp_r + WIN_AW'(1);
      bw_nxt = bw_inc;
    end
    if (cmd.ref_hi_load) begin
      hi_nxt = in_byte;
    end
    if (cmd.ref_start) begin
      off_nxt = off_in;
      rp_nxt  = wp_r - off_in - WIN_AW'(1);
      run_nxt = RUN_W'(hi_r[7:4]) + MIN_MATCH;
    end
    if (cmd.copy_step) begin
      rp_nxt  = rp_r + WIN_AW'(1);
      run_nxt = run_r - RUN_W'(1);
    end

    if (cmd.lit_emit) begin
      ov_nxt                = 1'b1;
      oi_nxt.out_byte       = in_byte;
      oi_nxt.last_of_item   = 1'b1;
      oi_nxt.stream_done    = reach_next;
      oi_nxt.distance_error = 1'b0;
    end else if (cmd.copy_step) begin
      ov_nxt                = 1'b1;
      oi_nxt.out_byte       = rd_q_r;
      oi_nxt.last_of_item   = stat.copy_last;
      oi_nxt.stream_done    = reach_next;
      oi_nxt.distance_error = 1'b0;
    end else if (cmd.err_emit) begin
      ov_nxt                = 1'b1;
      oi_nxt.out_byte       = 8'd0;
      oi_nxt.last_of_item   = 1'b1;
      oi_nxt.stream_done    = bw_ge_len;
      oi_nxt.distance_error = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      wp_r  <= '0;
      bw_r  <= '0;
      hi_r  <= 8'd0;
      run_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (len_we) begin
        len_r <= len_wdata;
      end
      wp_r  <= wp_nxt;
      bw_r  <= bw_nxt;
      hi_r  <= hi_nxt;
      run_r <= run_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    rp_r  <= rp_nxt;
    oi_r  <= oi_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign len_value = len_r;

endmodule

`default_nettype wire

[dv/lz10_decode_checker_pkg.sv]
// expected-result predictor and checker for the lz10 stream decompressor bench
// depends on lz10_pkg for the item types and window geometry
`timescale 1ns / 1ps

package lz10_decode_checker_pkg;
  import lz10_pkg::*;

  // what the decoder expects from the next payload byte
  typedef enum logic [1:0] {
    EXPECT_FLAG   = 2'd0,
    EXPECT_TOKEN  = 2'd1,
    EXPECT_REF_LO = 2'd2
  } decode_phase_t;

  class lz10_decode_checker;
    logic [7:0]        window [WIN_DEPTH];
    logic [WIN_AW-1:0] wr_ptr;
    logic [CNT_W-1:0]  n_written;
    logic [7:0]        flags;
    logic [3:0]        tok;
    decode_phase_t     phase;
    logic [7:0]        ref_hi;
    logic              ended;
    logic [LEN_W-1:0]  len_limit;
    out_item_t         expected_bytes [$];
    int                errors;

    function new();
      foreach (window[i]) window[i] = 8'h00;
      len_limit = '0;
      errors = 0;
      restart();
    endfunction

    // everything but the window, the limit, the queue and the error count goes back to a fresh stream
    function void restart();
      wr_ptr    = '0;
      n_written = '0;
      flags     = '0;
      tok       = 4'd8;
      phase     = EXPECT_FLAG;
      ref_hi    = '0;
      ended     = 1'b0;
    endfunction

    function void set_limit(logic [LEN_W-1:0] len);
      len_limit = len;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit reached();
      return n_written >= len_limit;
    endfunction

    function void queue_result(logic [7:0] b, logic last, logic bad);
      out_item_t r;
      r.out_byte       = b;
      r.last_of_item   = last;
      r.stream_done    = reached();
      r.distance_error = bad;
      expected_bytes.push_back(r);
    endfunction

    function void put_byte(logic [7:0] b);
      window[wr_ptr] = b;
      wr_ptr++;
      n_written++;
    endfunction

    // decode one accepted payload byte and queue the bytes it yields
    function void take_input(in_item_t it);
      logic [15:0]       pair;
      logic [12:0]       disp;
      logic [4:0]        run;
      logic [WIN_AW-1:0] rd_ptr;
      logic [7:0]        v;
      if (it.first_of_stream) restart();
      if (ended || reached()) return;
      // flag byte, also for any out-of-range phase or token index
      if (!(phase == EXPECT_TOKEN || phase == EXPECT_REF_LO) || tok >= 4'd8) begin
        flags = it.in_byte;
        tok   = 4'd0;
        phase = EXPECT_TOKEN;
        return;
      end
      if (phase == EXPECT_TOKEN) begin
        if (flags[3'd7 - tok[2:0]]) begin
          ref_hi = it.in_byte;
          phase  = EXPECT_REF_LO;
          return;
        end
        put_byte(it.in_byte);
        queue_result(it.in_byte, 1'b1, 1'b0);
      end else begin
        pair = {ref_hi, it.in_byte};
        run  = {1'b0, pair[15:12]} + MIN_MATCH;
        disp = {1'b0, pair[11:0]} + 13'd1;
        // reaching back past this stream's bytes ends it with one error result
        if (disp > n_written) begin
          queue_result(8'h00, 1'b1, 1'b1);
          ended = 1'b1;
          return;
        end
        for (int i = 0; i < run; i++) begin
          rd_ptr = wr_ptr - disp[WIN_AW-1:0];
          v = window[rd_ptr];
          put_byte(v);
          queue_result(v, i == run - 1, 1'b0);
        end
      end
      tok++;
      if (tok >= 4'd8) begin
        tok   = 4'd8;
        phase = EXPECT_FLAG;
      end else begin
        phase = EXPECT_TOKEN;
      end
      if (reached()) ended = 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    // compare one accepted result with the oldest expected byte
    task check_output(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected result, byte %02h", got.out_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last_of_item !== want.last_of_item)
        report($sformatf("last_of_item %b, want %b", got.last_of_item, want.last_of_item));
      if (got.stream_done !== want.stream_done)
        report($sformatf("stream_done %b, want %b", got.stream_done, want.stream_done));
      if (got.distance_error !== want.distance_error)
        report($sformatf("distance_error %b, want %b", got.distance_error,
                         want.distance_error));
    endtask
  endclass

endpackage

[dv/lz10_stream_decompressor_tb.sv]
// top of the lz10 stream decompressor bench: clock, reset, apb set-up of
// out_length, payload stream stimulus and result checking
// depends on lz10_pkg, lz10_decode_checker_pkg and the rtl of the block
`timescale 1ns / 1ps

module lz10_stream_decompressor_tb;
  import lz10_pkg::*;
  import lz10_decode_checker_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lz10_decode_checker dec_chk;
  logic [LEN_W-1:0]   cur_len;
  bit                 no_idle;
  int                 sent_items;
  int                 ph;

  lz10_stream_decompressor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(99) < 17);
  endfunction

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= idle_roll();
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) dec_chk.check_output(out_item);
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // one payload item; called and returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic first);
    in_item_t it;
    it.in_byte         = b;
    it.first_of_stream = first;
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dec_chk.take_input(it);
    sent_items++;
    @(negedge clk);
  endtask

  // drain all expected bytes, then give a trailing flag byte time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (dec_chk.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // apb write of out_length followed by a read-back
  task automatic cfg_write(input logic [LEN_W-1:0] len);
    logic [CFG_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OUT_LENGTH, 2'b00};
    pwdata  <= {{(CFG_DW-LEN_W){1'b0}}, len};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd[LEN_W-1:0] !== len)
      dec_chk.report($sformatf("out_length reads %06h, want %06h", rd[LEN_W-1:0], len));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_len = len;
    dec_chk.set_limit(len);
  endtask

  // one well-formed stream of flag groups; distances stay inside the bytes
  // written so far except for the odd deliberate bad one, which ends it
  task automatic send_stream(input int target, input int ref_pct, input int bad_pct,
                             input bit deep);
    logic [7:0]  tokens [$];
    logic [7:0]  flag;
    logic [15:0] ref_word;
    int          produced;
    int          run;
    int          back_dist;
    bit          stop;
    bit          first;
    produced = 0;
    stop     = 1'b0;
    first    = 1'b1;
    while (!stop) begin
      tokens.delete();
      flag = 8'h00;
      for (int t = 0; t < 8 && !stop; t++) begin
        if (produced > 0 && $urandom_range(99) < ref_pct) begin
          flag[7-t] = 1'b1;
          run = deep ? 18 : $urandom_range(18, 3);
          if (produced < WIN_DEPTH && $urandom_range(99) < bad_pct) begin
            back_dist = $urandom_range(WIN_DEPTH, produced + 1);
            stop = 1'b1;
          end else if (produced >= WIN_DEPTH && deep && $urandom_range(1) == 0) begin
            back_dist = WIN_DEPTH;
          end else begin
            back_dist = $urandom_range(produced > WIN_DEPTH ? WIN_DEPTH : produced, 1);
          end
          ref_word = 16'(((run - 3) << 12) | (back_dist - 1));
          tokens.push_back(ref_word[15:8]);
          tokens.push_back(ref_word[7:0]);
          produced += run;
        end else begin
          tokens.push_back(8'($urandom_range(255)));
          produced++;
        end
        if (produced >= target || produced >= cur_len) stop = 1'b1;
      end
      send_item(flag, first);
      first = 1'b0;
      foreach (tokens[i]) send_item(tokens[i], 1'b0);
    end
  endtask

  initial begin
    dec_chk    = new();
    sent_items = 0;
    no_idle    = 1'b0;
    cur_len    = '0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero length: every byte is swallowed
    cfg_write(24'd0);
    send_item(8'h55, 1'b1);
    send_item(8'hAA, 1'b0);
    settle();

    // literal, shortest copy, then a distance past the written bytes; tail ignored
    cfg_write(24'd24);
    send_item(8'h7F, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h12, 1'b0);
    // longest copy, literals, then a run that overshoots the length
    send_item(8'h44, 1'b1);
    send_item(8'hC3, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h7E, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h33, 1'b0);
    // reference as the very first token of a stream
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b0);
    settle();

    // one long stream of mostly longest copies, with no idling on either side
    no_idle = 1'b1;
    cfg_write(24'hFFFFFF);
    send_stream(1200, 90, 0, 1'b1);
    settle();
    no_idle = 1'b0;

    // random phases: extremes of out_length first, then mixed sizes
    ph = 0;
    while (sent_items < 320) begin
      case (ph)
        0: cfg_write(24'd1);
        1: cfg_write(24'hFFFFFF);
        2: cfg_write(24'd0);
        default: begin
          if ($urandom_range(3) == 0) cfg_write(LEN_W'($urandom_range(5000, 200)));
          else cfg_write(LEN_W'($urandom_range(60, 2)));
        end
      endcase
      repeat ($urandom_range(6, 3)) begin
        send_stream($urandom_range(80, 1), $urandom_range(60, 20), 5, 1'b0);
        // stray bytes, sometimes restarting mid-sequence
        if ($urandom_range(99) < 30)
          repeat ($urandom_range(4, 1))
            send_item(8'($urandom_range(255)), $urandom_range(99) < 20);
      end
      settle();
      ph++;
    end

    repeat (30) @(negedge clk);
    if (dec_chk.errors == 0 && dec_chk.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
